/* rtl/lpfc_pkg.sv */
// ----------------------------------------------------------------------------
// lpfc_pkg
// Types, codes and constants shared by the lamp panel flash controller.
// ----------------------------------------------------------------------------
package lpfc_pkg;

    localparam int LAMP_COUNT      = 8;
    localparam int PATTERN_ENTRIES = 16;
    localparam int TABLE_SIZE      = 16;
    localparam int ITEM_LAMPS      = 8;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 16;

    localparam int LAMP_MAIN    = 0;
    localparam int LAMP_PARTNER = 1;
    localparam int LAMP_STALL   = 5;

    localparam logic [0:0]  RST_MAIN_ROLE     = 1'b0;
    localparam logic [0:0]  RST_TIMER_MODE    = 1'b0;
    localparam logic [7:0]  RST_FLASH_PERIOD  = 8'd50;
    localparam logic [15:0] RST_STALL_PERIOD  = 16'd100;
    localparam logic [7:0]  RST_PANEL_MASK    = 8'hff;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_LAMP  = 2'd1,
        OP_STEP  = 2'd2,
        OP_ALARM = 2'd3
    } t_opcode;

    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_ON    = 2'd1;
    localparam logic [1:0] MODE_FLASH = 2'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAIN_ROLE    = 3'd0,
        CFG_TIMER_MODE   = 3'd1,
        CFG_FLASH_PERIOD = 3'd2,
        CFG_STALL_PERIOD = 3'd3,
        CFG_PANEL_MASK   = 3'd4
    } t_cfg_reg;

    localparam logic [7:0] PATTERN_TABLE [TABLE_SIZE] = '{
        8'h00, 8'h40, 8'h20, 8'h60, 8'h02, 8'h42, 8'h22, 8'h62,
        8'h01, 8'h41, 8'h21, 8'h61, 8'h03, 8'h43, 8'h23, 8'h63
    };

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] lamp_mask;
        logic [1:0] lamp_mode;
        logic [3:0] pattern_index;
        logic       partner_absent;
    } t_in_item;

    typedef struct packed {
        logic [7:0] lamp_drive;
        logic       lamp_written;
        logic [1:0] heartbeat;
        logic       partner_live;
    } t_out_item;

    typedef struct packed {
        logic fire;
        logic tick_flash;
        logic b_apply;
        logic b_flash;
        logic b_on;
    } t_cell_ctrl;

    typedef struct packed {
        logic clear;
        logic set;
        logic force_en;
        logic force_val;
        logic toggle;
    } t_cell_bits;

    function automatic logic [7:0] pattern_of(input logic [3:0] idx);
        logic [7:0] pat;
        pat = 8'h00;
        if (int'(idx) < PATTERN_ENTRIES && int'(idx) < TABLE_SIZE) begin
            pat = PATTERN_TABLE[idx];
        end
        return pat;
    endfunction

endpackage

/* rtl/lpfc_cell.sv */
// ----------------------------------------------------------------------------
// lpfc_cell
// One lamp: level, flash enable and flash countdown; extends the flashing chain.
// ----------------------------------------------------------------------------
module lpfc_cell
    import lpfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_cell_bits i_bits,
    input  logic [7:0] i_flash_period,
    input  logic       i_any_flash,
    output logic       o_any_flash,
    output logic       o_lamp_next
);

    logic       r_lamp;
    logic       n_lamp;
    logic       r_flash;
    logic       n_flash;
    logic [7:0] r_count;
    logic [7:0] n_count;
    logic [7:0] count_dec;

    assign count_dec   = r_count - 8'd1;
    assign o_any_flash = i_any_flash | r_flash;
    assign o_lamp_next = n_lamp;

    always_comb begin
        n_lamp  = r_lamp;
        n_flash = r_flash;
        n_count = r_count;
        if (i_ctrl.fire) begin
            if (i_ctrl.tick_flash && r_flash) begin
                if (count_dec == 8'd0) begin
                    n_count = i_flash_period;
                    n_lamp  = ~r_lamp;
                end else begin
                    n_count = count_dec;
                end
            end
            if (i_bits.force_en) begin
                n_lamp = i_bits.force_val;
            end
            if (i_bits.toggle) begin
                n_lamp = ~n_lamp;
            end
            if (i_bits.clear) begin
                n_count = 8'd0;
                n_flash = 1'b0;
                n_lamp  = 1'b0;
            end
            if (i_ctrl.b_apply) begin
                if (i_ctrl.b_flash) begin
                    n_flash = i_bits.set;
                    if (i_bits.set) begin
                        n_count = i_flash_period;
                        n_lamp  = 1'b1;
                    end
                end else if (i_bits.set) begin
                    n_count = 8'd0;
                    n_flash = 1'b0;
                    n_lamp  = i_ctrl.b_on;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lamp  <= 1'b0;
            r_flash <= 1'b0;
            r_count <= 8'd0;
        end else begin
            r_lamp  <= n_lamp;
            r_flash <= n_flash;
            r_count <= n_count;
        end
    end

endmodule

/* rtl/lamp_panel_flash_controller.sv */
// ----------------------------------------------------------------------------
// lamp_panel_flash_controller
// Lamp panel driver: ticks, lamp commands, step and alarm patterns.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one item (tick, lamp command,
// step pattern or alarm pattern). Output channel: o_out_valid / i_out_stall
// carry one result item per input item: active-low lamp port value, write
// flag, heartbeat bits and partner liveness.
// Configuration: i_cfg_valid / o_cfg_ready with a register index and data;
// o_cfg_ready is always high. Write only while no item is in flight.
// Latency: the result is valid in the cycle after the item is accepted.
// Throughput: one item per cycle while not stalled; each lamp cell updates
// its countdown in the same cycle; the single output register sets the rate.
// Reset: lamps, flash state, counters and heartbeat clear; registers take
// their defaults (flash period 50, stall period 100, panel mask all ones).
// Receiver stall: the output register holds its item; the input is stalled
// only while that register is full and the receiver stalls.
// ----------------------------------------------------------------------------
module lamp_panel_flash_controller
    import lpfc_pkg::*;
#(
    parameter int LAMP_CNT = LAMP_COUNT
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_item               i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_item              o_out_item,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic        r_main_role;
    logic        r_timer_mode;
    logic [7:0]  r_flash_period;
    logic [15:0] r_stall_period;
    logic [7:0]  r_panel_mask;

    logic [15:0] r_stall_ticks;
    logic [15:0] n_stall_ticks;
    logic [1:0]  r_heartbeat;
    logic [1:0]  n_heartbeat;
    logic        r_partner;
    logic        n_partner;

    logic        r_out_valid;
    t_out_item   r_out_item;
    t_out_item   n_out_item;

    logic        in_acc;
    logic        timer_tick;
    logic        stall_wrap;
    logic [15:0] stall_inc;
    logic [7:0]  a_src;
    logic [7:0]  b_src;
    logic        written;
    t_cell_ctrl  ctrl;

    logic [LAMP_CNT-1:0] a_vec;
    logic [LAMP_CNT-1:0] b_vec;
    logic [LAMP_CNT-1:0] lamp_next;
    logic [LAMP_CNT:0]   any_chain;
    t_cell_bits          cell_bits [LAMP_CNT];
    logic [7:0]          drive_view;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    assign stall_inc  = r_stall_ticks + 16'd1;
    assign stall_wrap = stall_inc >= r_stall_period;
    assign any_chain[0] = 1'b0;

    always_comb begin
        a_src           = 8'h00;
        b_src           = 8'h00;
        timer_tick      = 1'b0;
        ctrl.fire       = in_acc;
        ctrl.tick_flash = 1'b0;
        ctrl.b_flash    = 1'b0;
        ctrl.b_on       = 1'b0;
        ctrl.b_apply    = |b_vec;
        written         = 1'b0;
        n_stall_ticks   = r_stall_ticks;
        n_heartbeat     = r_heartbeat;
        n_partner       = r_partner;
        unique case (t_opcode'(i_in_item.opcode))
            OP_TICK: begin
                n_heartbeat = r_heartbeat ^ 2'b11;
                if (r_timer_mode) begin
                    timer_tick    = 1'b1;
                    n_partner     = !i_in_item.partner_absent;
                    n_stall_ticks = stall_wrap ? 16'd0 : stall_inc;
                    written       = 1'b1;
                end else begin
                    ctrl.tick_flash = 1'b1;
                    written         = any_chain[LAMP_CNT];
                end
            end
            OP_LAMP: begin
                b_src        = i_in_item.lamp_mask;
                ctrl.b_flash = i_in_item.lamp_mode == MODE_FLASH;
                ctrl.b_on    = i_in_item.lamp_mode == MODE_ON;
                written      = |b_vec;
            end
            OP_STEP: begin
                a_src     = r_panel_mask;
                b_src     = pattern_of(i_in_item.pattern_index);
                ctrl.b_on = 1'b1;
                written   = (|a_vec) || (|b_vec);
            end
            OP_ALARM: begin
                a_src        = r_panel_mask;
                b_src        = pattern_of(i_in_item.pattern_index);
                ctrl.b_flash = 1'b1;
                written      = (|a_vec) || (|b_vec);
            end
        endcase
    end

    for (genvar g = 0; g < LAMP_CNT; g++) begin : g_cell
        if (g < ITEM_LAMPS) begin : g_map
            assign a_vec[g] = a_src[g];
            assign b_vec[g] = b_src[g];
        end else begin : g_pad
            assign a_vec[g] = 1'b0;
            assign b_vec[g] = 1'b0;
        end

        assign cell_bits[g].clear     = a_vec[g];
        assign cell_bits[g].set       = b_vec[g];
        assign cell_bits[g].force_en  = timer_tick && (g == LAMP_MAIN || g == LAMP_PARTNER);
        assign cell_bits[g].force_val = (g == LAMP_MAIN) ? r_main_role
                                                         : !i_in_item.partner_absent;
        assign cell_bits[g].toggle    = timer_tick && stall_wrap && (g == LAMP_STALL);

        lpfc_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctrl         (ctrl),
            .i_bits         (cell_bits[g]),
            .i_flash_period (r_flash_period),
            .i_any_flash    (any_chain[g]),
            .o_any_flash    (any_chain[g+1]),
            .o_lamp_next    (lamp_next[g])
        );
    end

    for (genvar g = 0; g < ITEM_LAMPS; g++) begin : g_view
        if (g < LAMP_CNT) begin : g_lamp
            assign drive_view[g] = ~lamp_next[g];
        end else begin : g_none
            assign drive_view[g] = 1'b1;
        end
    end

    always_comb begin
        n_out_item.lamp_drive   = drive_view;
        n_out_item.lamp_written = written;
        n_out_item.heartbeat    = n_heartbeat;
        n_out_item.partner_live = n_partner;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_role    <= RST_MAIN_ROLE;
            r_timer_mode   <= RST_TIMER_MODE;
            r_flash_period <= RST_FLASH_PERIOD;
            r_stall_period <= RST_STALL_PERIOD;
            r_panel_mask   <= RST_PANEL_MASK;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MAIN_ROLE:    r_main_role    <= i_cfg_data[0];
                CFG_TIMER_MODE:   r_timer_mode   <= i_cfg_data[0];
                CFG_FLASH_PERIOD: r_flash_period <= i_cfg_data[7:0];
                CFG_STALL_PERIOD: r_stall_period <= i_cfg_data[15:0];
                CFG_PANEL_MASK:   r_panel_mask   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stall_ticks <= 16'd0;
            r_heartbeat   <= 2'b00;
            r_partner     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_acc) begin
                r_stall_ticks <= n_stall_ticks;
                r_heartbeat   <= n_heartbeat;
                r_partner     <= n_partner;
                r_out_valid   <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

/* rtl/lpfc_checker.sv */
// ----------------------------------------------------------------------------
// lpfc_checker
// Port-level checks for the lamp panel flash controller, bound to the top.
// ----------------------------------------------------------------------------
module lpfc_checker
    import lpfc_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input t_in_item               i_in_item,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input t_out_item              o_out_item
);

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    a_stall_only_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall)
    ) else $error("input stalled while output register can take an item");

    a_result_follows: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid
    ) else $error("accepted item produced no result");

    a_lamp_on: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_item.opcode == OP_LAMP && i_in_item.lamp_mode == MODE_ON
            && i_in_item.lamp_mask[0])
        |=> (o_out_item.lamp_drive[0] == 1'b0 && o_out_item.lamp_written)
    ) else $error("lamp on command did not light lamp 0");

    a_hold_stalled: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item))
    ) else $error("stalled result changed");

endmodule

bind lamp_panel_flash_controller lpfc_checker u_lpfc_checker (.*);

/* bench/lpfc_panel_checker.sv */
// ----------------------------------------------------------------------------
// lpfc_panel_checker
// Tracks the lamp panel state on its own, predicts one result per accepted
// item and compares every accepted result against the oldest prediction.
// Configuration writes are mirrored as they are accepted on the port.
// ----------------------------------------------------------------------------
module lpfc_panel_checker
    import lpfc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  t_in_item               i_in_item,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  t_out_item              i_out_item,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic        main_role_q;
    logic        timer_mode_q;
    logic [7:0]  flash_period_q;
    logic [15:0] stall_period_q;
    logic [7:0]  panel_mask_q;

    logic [7:0]  lamp_q;
    logic [7:0]  flashing_q;
    logic [7:0]  countdown_q [LAMP_COUNT];
    logic [15:0] stall_cnt_q;
    logic [1:0]  beat_q;
    logic        partner_q;

    t_out_item   expected_panel [$];
    t_out_item   predicted_item;
    int          fail_count    = 0;
    int          results_seen  = 0;

    function automatic logic [7:0] pattern_lamps(input logic [3:0] idx);
        return {1'b0, idx[0], idx[1], 3'b000, idx[2], idx[3]};
    endfunction

    task automatic reset_panel();
        main_role_q    = RST_MAIN_ROLE;
        timer_mode_q   = RST_TIMER_MODE;
        flash_period_q = RST_FLASH_PERIOD;
        stall_period_q = RST_STALL_PERIOD;
        panel_mask_q   = RST_PANEL_MASK;
        lamp_q         = '0;
        flashing_q     = '0;
        stall_cnt_q    = '0;
        beat_q         = '0;
        partner_q      = 1'b0;
        for (int n = 0; n < LAMP_COUNT; n++) begin
            countdown_q[n] = '0;
        end
    endtask

    task automatic write_config(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        case (t_cfg_reg'(idx))
            CFG_MAIN_ROLE:    main_role_q    = data[0];
            CFG_TIMER_MODE:   timer_mode_q   = data[0];
            CFG_FLASH_PERIOD: flash_period_q = data[7:0];
            CFG_STALL_PERIOD: stall_period_q = data[15:0];
            CFG_PANEL_MASK:   panel_mask_q   = data[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_lamp_cmd(input logic [7:0] mask, input logic [1:0] mode,
                                  output logic wrote);
        wrote = 1'b0;
        if (mask != 8'h00) begin
            wrote = 1'b1;
            for (int n = 0; n < LAMP_COUNT; n++) begin
                if (mask[n]) begin
                    if (mode == MODE_FLASH) begin
                        countdown_q[n] = flash_period_q;
                    end else begin
                        countdown_q[n] = '0;
                        flashing_q[n]  = 1'b0;
                    end
                end
            end
            if (mode == MODE_FLASH) begin
                flashing_q = mask;
                lamp_q     = lamp_q | mask;
            end else if (mode == MODE_ON) begin
                lamp_q = lamp_q | mask;
            end else begin
                lamp_q = lamp_q & ~mask;
            end
        end
    endtask

    task automatic advance_tick(input logic absent, output logic wrote);
        beat_q = beat_q ^ 2'b11;
        wrote  = 1'b0;
        if (timer_mode_q) begin
            wrote                = 1'b1;
            lamp_q[LAMP_PARTNER] = !absent;
            partner_q            = !absent;
            lamp_q[LAMP_MAIN]    = main_role_q;
            stall_cnt_q          = stall_cnt_q + 16'd1;
            if (stall_cnt_q >= stall_period_q) begin
                stall_cnt_q        = '0;
                lamp_q[LAMP_STALL] = !lamp_q[LAMP_STALL];
            end
        end else if (flashing_q != 8'h00) begin
            wrote = 1'b1;
            for (int n = 0; n < LAMP_COUNT; n++) begin
                if (flashing_q[n]) begin
                    countdown_q[n] = countdown_q[n] - 8'd1;
                    if (countdown_q[n] == 8'd0) begin
                        countdown_q[n] = flash_period_q;
                        lamp_q[n]      = !lamp_q[n];
                    end
                end
            end
        end
    endtask

    task automatic predict_panel(input t_in_item it, output t_out_item res);
        logic wrote;
        logic wrote_pat;
        wrote     = 1'b0;
        wrote_pat = 1'b0;
        case (t_opcode'(it.opcode))
            OP_TICK: advance_tick(it.partner_absent, wrote);
            OP_LAMP: apply_lamp_cmd(it.lamp_mask, it.lamp_mode, wrote);
            default: begin
                apply_lamp_cmd(panel_mask_q, MODE_OFF, wrote);
                apply_lamp_cmd(pattern_lamps(it.pattern_index),
                               (it.opcode == OP_STEP) ? MODE_ON : MODE_FLASH, wrote_pat);
            end
        endcase
        res.lamp_drive   = ~lamp_q;
        res.lamp_written = wrote | wrote_pat;
        res.heartbeat    = beat_q;
        res.partner_live = partner_q;
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        results_seen++;
        if (expected_panel.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("%0t: result %0d with none expected: drive=%h written=%b beat=%b live=%b",
                         $time, results_seen, got.lamp_drive, got.lamp_written,
                         got.heartbeat, got.partner_live);
            end
        end else begin
            want = expected_panel.pop_front();
            if (got.lamp_drive !== want.lamp_drive || got.lamp_written !== want.lamp_written ||
                got.heartbeat !== want.heartbeat || got.partner_live !== want.partner_live) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("%0t: result %0d expected drive=%h written=%b beat=%b live=%b",
                             $time, results_seen, want.lamp_drive, want.lamp_written,
                             want.heartbeat, want.partner_live);
                    $display("%0t: result %0d actual   drive=%h written=%b beat=%b live=%b",
                             $time, results_seen, got.lamp_drive, got.lamp_written,
                             got.heartbeat, got.partner_live);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_panel();
            expected_panel.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_result(i_out_item);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                write_config(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && !i_in_stall) begin
                predict_panel(i_in_item, predicted_item);
                expected_panel.push_back(predicted_item);
            end
        end
        o_pending    = expected_panel.size();
        o_fail_count = fail_count;
    end

endmodule

/* bench/tb_lamp_panel_flash_controller.sv */
// ----------------------------------------------------------------------------
// tb_lamp_panel_flash_controller
// Drives directed and random lamp panel items through several register
// settings and idle patterns, with a long receiver hold-off; a checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_lamp_panel_flash_controller;
    import lpfc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int         PHASE_ITEMS = 210;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    t_in_item               in_item   = '0;
    logic                   out_stall = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_stall;
    logic                   out_valid;
    t_out_item              out_item;
    logic                   cfg_ready;

    int   fail_count;
    int   pending;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic hold_go     = 1'b0;
    logic long_hold   = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    lamp_panel_flash_controller u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    lpfc_panel_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        out_stall <= long_hold || ($urandom_range(99) < rx_idle_pct);
    end

    // hold the receiver off long enough to back up the input
    initial begin
        wait (hold_go);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (120) @(posedge clk);
        long_hold <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("lamp_panel_flash_controller: mismatch");
        $finish;
    end

    function automatic t_in_item panel_item(input logic [1:0] op, input logic [7:0] mask,
                                            input logic [1:0] mode, input logic [3:0] idx,
                                            input logic absent);
        t_in_item it;
        it.opcode         = op;
        it.lamp_mask      = mask;
        it.lamp_mode      = mode;
        it.pattern_index  = idx;
        it.partner_absent = absent;
        return it;
    endfunction

    function automatic t_in_item random_panel_item();
        t_in_item it;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            it.opcode = OP_TICK;
        end else if (pick < 75) begin
            it.opcode = OP_LAMP;
        end else if (pick < 88) begin
            it.opcode = OP_STEP;
        end else begin
            it.opcode = OP_ALARM;
        end
        case ($urandom_range(7))
            0:       it.lamp_mask = 8'h00;
            1:       it.lamp_mask = 8'hff;
            default: it.lamp_mask = 8'($urandom_range(255));
        endcase
        it.lamp_mode      = 2'($urandom_range(3));
        it.pattern_index  = 4'($urandom_range(15));
        it.partner_absent = 1'($urandom_range(1));
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic load_settings(input logic main_role, input logic timer_mode,
                                 input logic [7:0] flash_period,
                                 input logic [15:0] stall_period,
                                 input logic [7:0] panel_mask);
        write_reg(CFG_MAIN_ROLE, {15'd0, main_role});
        write_reg(CFG_TIMER_MODE, {15'd0, timer_mode});
        write_reg(CFG_FLASH_PERIOD, {8'd0, flash_period});
        write_reg(CFG_STALL_PERIOD, stall_period);
        write_reg(CFG_PANEL_MASK, {8'd0, panel_mask});
        cfg_valid <= 1'b0;
    endtask

    // drop valid and wait for every result
    task automatic drain_panel();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(input logic main_role, input logic timer_mode,
                             input logic [7:0] flash_period, input logic [15:0] stall_period,
                             input logic [7:0] panel_mask, input int tx_pct, input int rx_pct,
                             input logic with_hold);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        load_settings(main_role, timer_mode, flash_period, stall_period, panel_mask);
        if (with_hold) begin
            hold_go <= 1'b1;
        end
        repeat (PHASE_ITEMS) send_item(random_panel_item());
        drain_panel();
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_settings(1'b1, 1'b0, 8'd2, 16'd2, 8'hff);
        send_item(panel_item(OP_TICK,  8'h00, MODE_OFF,   4'd0,  1'b0));
        send_item(panel_item(OP_LAMP,  8'h00, MODE_ON,    4'd0,  1'b0));
        send_item(panel_item(OP_LAMP,  8'hff, MODE_ON,    4'd0,  1'b0));
        send_item(panel_item(OP_LAMP,  8'h0f, MODE_OFF,   4'd0,  1'b0));
        send_item(panel_item(OP_LAMP,  8'hf0, MODE_SPARE, 4'd0,  1'b0));
        send_item(panel_item(OP_LAMP,  8'ha5, MODE_FLASH, 4'd0,  1'b0));
        send_item(panel_item(OP_TICK,  8'h00, MODE_OFF,   4'd0,  1'b1));
        send_item(panel_item(OP_TICK,  8'hff, MODE_SPARE, 4'd15, 1'b0));
        send_item(panel_item(OP_LAMP,  8'h5a, MODE_FLASH, 4'd0,  1'b0));
        send_item(panel_item(OP_LAMP,  8'h02, MODE_ON,    4'd0,  1'b0));
        send_item(panel_item(OP_TICK,  8'h00, MODE_OFF,   4'd0,  1'b0));
        send_item(panel_item(OP_STEP,  8'h00, MODE_OFF,   4'd15, 1'b0));
        send_item(panel_item(OP_STEP,  8'hff, MODE_FLASH, 4'd0,  1'b1));
        send_item(panel_item(OP_ALARM, 8'h00, MODE_OFF,   4'd15, 1'b0));
        send_item(panel_item(OP_TICK,  8'h00, MODE_OFF,   4'd0,  1'b0));
        send_item(panel_item(OP_TICK,  8'h00, MODE_OFF,   4'd0,  1'b0));
        send_item(panel_item(OP_ALARM, 8'h00, MODE_OFF,   4'd0,  1'b0));
        send_item(panel_item(OP_LAMP,  8'hff, MODE_FLASH, 4'd0,  1'b0));
        send_item(panel_item(OP_TICK,  8'h00, MODE_OFF,   4'd0,  1'b0));
        drain_panel();

        load_settings(1'b1, 1'b1, 8'd0, 16'd0, 8'h63);
        send_item(panel_item(OP_TICK,  8'h00, MODE_OFF,   4'd0,  1'b0));
        send_item(panel_item(OP_TICK,  8'h00, MODE_OFF,   4'd0,  1'b1));
        send_item(panel_item(OP_LAMP,  8'h80, MODE_FLASH, 4'd0,  1'b0));
        send_item(panel_item(OP_TICK,  8'h00, MODE_OFF,   4'd0,  1'b0));
        send_item(panel_item(OP_STEP,  8'h00, MODE_OFF,   4'd6,  1'b0));
        drain_panel();

        run_phase(1'b0, 1'b0, 8'd1,   16'd1,     8'hff, 19, 80, 1'b0);
        run_phase(1'b1, 1'b1, 8'd3,   16'd2,     8'h63, 19, 80, 1'b0);
        run_phase(1'b0, 1'b0, 8'd255, 16'd65535, 8'h00, 19, 80, 1'b0);
        run_phase(1'b1, 1'b0, 8'd0,   16'd0,     8'h55, 80, 19, 1'b0);
        run_phase(1'b0, 1'b1, 8'd2,   16'd0,     8'hff, 80, 19, 1'b0);
        run_phase(1'b1, 1'b1, 8'd7,   16'd65535, 8'haa, 80, 19, 1'b0);
        run_phase(1'b0, 1'b0, 8'd4,   16'd3,     8'h0f, 0,  0,  1'b1);
        run_phase(1'b1, 1'b1, 8'd1,   16'd5,     8'hf0, 0,  0,  1'b0);
        run_phase(1'b0, 1'b0, 8'd2,   16'd100,   8'hff, 0,  0,  1'b0);

        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("lamp_panel_flash_controller: match");
        end else begin
            $display("lamp_panel_flash_controller: mismatch");
        end
        $finish;
    end

endmodule
